// ----- rtl/core/eda_pkg.sv -----
// Shared constants and types for the Euclidean distance accumulator.
`default_nettype none
package eda_pkg;

	localparam int MAX_DIMS    = 256;
	localparam int COORD_WIDTH = 16;

	// Pair counter holds 0..MAX_DIMS
	localparam int CNT_W   = $clog2(MAX_DIMS + 1);
	// Difference and magnitude of two coordinates
	localparam int AD_W    = COORD_WIDTH + 1;
	// Magnitude widened so the 2^20 range check always has bits to look at
	localparam int SQ_IN_W = 20;
	localparam int ADX_W   = (AD_W > SQ_IN_W + 1) ? AD_W : SQ_IN_W + 1;

	localparam int SUM_W   = 40;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Root of sum * 2^16: 56-bit radicand, 28-bit result
	localparam int FRAC_W  = 16;
	localparam int RAD_W   = SUM_W + FRAC_W;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int STEP_W  = $clog2(ROOT_W);

	// Finished vector, handed from the accumulator to the root unit
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ovf;
	} vec_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Root unit states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/euclidean_distance_accumulator.sv -----
// Top level of the Euclidean distance accumulator.
// Accepts one coordinate pair per cycle while in_stall is low; each pair's squared
// difference is added to a per-vector sum, and the pair flagged last_dim closes the
// vector. The vector then yields its squared distance (saturated at 2^40-1;
// too_many_dims set when more than MAX_DIMS pairs arrived or the sum saturated)
// and floor(sqrt * 256). Pairs pass through the subtract, square and accumulate
// stages. The root comes from a shared bit-pair unit that takes one vector at a
// time; a four-entry queue lets new vectors accumulate meanwhile, and a full queue
// stalls the front end when the next vector finishes.
`default_nettype none
module euclidean_distance_accumulator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] coord_a,
	input  wire logic signed [15:0] coord_b,
	input  wire logic               last_dim,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [39:0]             distance_squared,
	output logic [27:0]             distance_root,
	output logic                    too_many_dims
);

	eda_pkg::q_stat_t  q_stat;
	eda_pkg::vec_res_t q_wr, q_rd;
	logic              q_push, q_pop;

	eda_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.coord_a  (coord_a),
		.coord_b  (coord_b),
		.last_dim (last_dim),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_data   (q_wr)
	);

	eda_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.stat    (q_stat)
	);

	eda_root u_root (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_stat           (q_stat),
		.q_data           (q_rd),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.distance_squared (distance_squared),
		.distance_root    (distance_root),
		.too_many_dims    (too_many_dims)
	);

endmodule
`default_nettype wire

// ----- rtl/core/eda_front.sv -----
// Front end: takes coordinate pairs, squares the difference and accumulates per vector.
`default_nettype none
module eda_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [15:0]        coord_a,
	input  wire logic signed [15:0]        coord_b,
	input  wire logic                      last_dim,
	input  wire eda_pkg::q_stat_t          q_stat,
	output logic                           q_push,
	output eda_pkg::vec_res_t              q_data
);

	logic                           en;
	logic                           in_fire;
	logic [eda_pkg::AD_W-1:0]       a_x, b_x, d;
	logic [eda_pkg::AD_W-1:0]       ad_s1;
	logic                           v_s1, last_s1;
	logic [eda_pkg::ADX_W-1:0]      adx;
	logic [eda_pkg::SQ_IN_W-1:0]    m;
	logic [eda_pkg::SUM_W-1:0]      prod;
	logic [eda_pkg::SUM_W-1:0]      sq_s2;
	logic                           big_s2, v_s2, last_s2;
	logic [eda_pkg::SUM_W-1:0]      sum_q, sum_n;
	logic [eda_pkg::CNT_W-1:0]      cnt_q, cnt_n;
	logic                           ovf_q, ovf_n;
	logic [eda_pkg::SUM_W:0]        sum_ext;
	logic                           acc_fire;

	// Stall the whole pipe only when a finished vector cannot enter the queue
	assign en       = !(v_s2 && last_s2 && q_stat.full);
	assign in_stall = !en;
	assign in_fire  = in_valid && en;

	assign a_x = {coord_a[eda_pkg::COORD_WIDTH-1], coord_a[eda_pkg::COORD_WIDTH-1:0]};
	assign b_x = {coord_b[eda_pkg::COORD_WIDTH-1], coord_b[eda_pkg::COORD_WIDTH-1:0]};
	assign d   = a_x - b_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1   <= d[eda_pkg::AD_W-1] ? (~d + 1'b1) : d;
			last_s1 <= last_dim;
			sq_s2   <= prod;
			big_s2  <= |adx[eda_pkg::ADX_W-1:eda_pkg::SQ_IN_W];
			last_s2 <= last_s1;
		end
	end

	assign adx  = eda_pkg::ADX_W'(ad_s1);
	assign m    = adx[eda_pkg::SQ_IN_W-1:0];
	assign prod = m * m;

	// Accumulate with saturation on dimension overflow or sum overflow
	assign sum_ext  = {1'b0, sum_q} + {1'b0, sq_s2};
	assign acc_fire = v_s2 && en;

	always_comb begin
		sum_n = sum_q;
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		if (cnt_q >= eda_pkg::CNT_W'(eda_pkg::MAX_DIMS)) begin
			ovf_n = 1'b1;
			sum_n = eda_pkg::SUM_MAX;
		end else begin
			cnt_n = cnt_q + 1'b1;
			if (big_s2 || sum_ext[eda_pkg::SUM_W]) begin
				ovf_n = 1'b1;
				sum_n = eda_pkg::SUM_MAX;
			end else begin
				sum_n = sum_ext[eda_pkg::SUM_W-1:0];
			end
		end
	end

	assign q_push      = acc_fire && last_s2;
	assign q_data.sum  = sum_n;
	assign q_data.ovf  = ovf_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc_fire) begin
			if (last_s2) begin
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_n;
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= eda_pkg::CNT_W'(eda_pkg::MAX_DIMS))
		else $error("pair count beyond MAX_DIMS");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> sum_q == eda_pkg::SUM_MAX)
		else $error("overflow flag set without saturated sum");

	a_clear_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> (sum_q == '0) && (cnt_q == '0) && !ovf_q)
		else $error("vector state not cleared after last pair");

endmodule
`default_nettype wire

// ----- rtl/core/eda_queue.sv -----
// Short queue of finished vector sums between the accumulator and the root unit.
`default_nettype none
module eda_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire eda_pkg::vec_res_t wr_data,
	input  wire logic              pop,
	output eda_pkg::vec_res_t      rd_data,
	output eda_pkg::q_stat_t       stat
);

	eda_pkg::vec_res_t           entry_q [eda_pkg::Q_DEPTH];
	logic [eda_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [eda_pkg::QCNT_W-1:0]  cnt_q;
	logic                        do_push, do_pop;

	assign stat.full  = cnt_q == eda_pkg::QCNT_W'(eda_pkg::Q_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("pop from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= eda_pkg::QCNT_W'(eda_pkg::Q_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/core/eda_root.sv -----
// Back end: bit-pair square root of each vector sum and the output register.
`default_nettype none
module eda_root (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire eda_pkg::q_stat_t            q_stat,
	input  wire eda_pkg::vec_res_t           q_data,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [39:0]                      distance_squared,
	output logic [27:0]                      distance_root,
	output logic                             too_many_dims
);

	logic [1:0]                     state_q;
	logic [eda_pkg::RAD_W-1:0]      x_q;
	logic [eda_pkg::REM_W-1:0]      rem_q;
	logic [eda_pkg::ROOT_W-1:0]     root_q;
	logic [eda_pkg::STEP_W-1:0]     step_q;
	logic [eda_pkg::SUM_W-1:0]      sum_q;
	logic                           ovf_q;
	logic                           out_valid_q;
	logic [eda_pkg::REM_W+1:0]      rem_sh, trial, rem_n;
	logic [eda_pkg::ROOT_W-1:0]     root_n;
	logic                           ge;
	logic                           last_step;
	logic                           out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == eda_pkg::ST_IDLE) && !q_stat.empty;
	assign last_step = step_q == eda_pkg::STEP_W'(eda_pkg::ROOT_W - 1);

	// One root bit per cycle: bring down two radicand bits, try subtracting 4r+1
	assign rem_sh = {rem_q, x_q[eda_pkg::RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign rem_n  = ge ? rem_sh - trial : rem_sh;
	assign root_n = {root_q[eda_pkg::ROOT_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q    <= {q_data.sum, {eda_pkg::FRAC_W{1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
			sum_q  <= q_data.sum;
			ovf_q  <= q_data.ovf;
		end else if (state_q == eda_pkg::ST_CALC) begin
			x_q    <= x_q << 2;
			rem_q  <= rem_n[eda_pkg::REM_W-1:0];
			root_q <= root_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eda_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				eda_pkg::ST_IDLE: begin
					step_q <= '0;
					if (q_pop)
						state_q <= eda_pkg::ST_CALC;
				end
				eda_pkg::ST_CALC: begin
					step_q <= step_q + 1'b1;
					if (last_step)
						state_q <= out_free ? eda_pkg::ST_IDLE : eda_pkg::ST_HOLD;
				end
				eda_pkg::ST_HOLD: begin
					if (out_free)
						state_q <= eda_pkg::ST_IDLE;
				end
				default: state_q <= eda_pkg::ST_IDLE;
			endcase
		end
	end

	// Output register: load the finished result once the previous one is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == eda_pkg::ST_CALC && last_step) ||
			               (state_q == eda_pkg::ST_HOLD);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == eda_pkg::ST_CALC && last_step) begin
				distance_squared <= sum_q;
				distance_root    <= root_n;
				too_many_dims    <= ovf_q;
			end else if (state_q == eda_pkg::ST_HOLD) begin
				distance_squared <= sum_q;
				distance_root    <= root_q;
				too_many_dims    <= ovf_q;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == eda_pkg::ST_CALC |-> step_q < eda_pkg::STEP_W'(eda_pkg::ROOT_W))
		else $error("root step counter out of range");

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == eda_pkg::ST_HOLD |-> out_valid_q)
		else $error("root result held with empty output register");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == eda_pkg::ST_CALC && step_q == '0)
		else $error("root unit did not start after pop");

endmodule
`default_nettype wire
